[rtl/core/cst_pkg.sv]
// ---------------------------------------------------------------------------
// cst_pkg
// Shared types, codes and helpers for the countdown session timer.
// ---------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

  localparam int CST_TIME_BITS = 32;

  localparam int REQ_W  = 2;
  localparam int NOW_W  = 32;
  localparam int DISP_W = 14;
  localparam int DOT_W  = 4;
  localparam int MODE_W = 3;
  localparam int DUR_W  = 7;
  // time left below the saturation point fits in this many bits
  localparam int REM_W  = 23;

  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BTN_A = 2'd1;
  localparam logic [REQ_W-1:0] REQ_BTN_B = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE  = 3'd0,
    MODE_RUN   = 3'd1,
    MODE_PAUSE = 3'd2,
    MODE_TENS  = 3'd3,
    MODE_UNITS = 3'd4,
    MODE_RING  = 3'd5
  } mode_t;

  localparam logic [DUR_W-1:0] DUR_RESET  = 7'd25;
  localparam int               MS_PER_MIN = 60000;
  // 100 minutes in ms: from here on the display saturates
  localparam logic [REM_W-1:0] SAT_MS     = 23'd6000000;
  localparam logic [DISP_W-1:0] DISP_SAT  = 14'd9959;

  localparam logic [DOT_W-1:0] DOTS_IDLE  = 4'b0100;
  localparam logic [DOT_W-1:0] DOTS_RUN   = 4'b0101;
  localparam logic [DOT_W-1:0] DOTS_PAUSE = 4'b0110;
  localparam logic [DOT_W-1:0] DOTS_TENS  = 4'b0111;
  localparam logic [DOT_W-1:0] DOTS_UNITS = 4'b1011;
  localparam logic [DOT_W-1:0] DOTS_RING  = 4'b1111;

  // display request handed from the state stage to the display pipeline
  typedef struct packed {
    mode_t              mode;
    logic               direct;
    logic [DISP_W-1:0]  dval;
    logic [REM_W-1:0]   rem;
  } disp_req_t;

  // units digit of a minute count, tens taken as (x * 205) >> 11
  function automatic logic [3:0] ones_digit(input logic [DUR_W-1:0] dur);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  q10;
    prod = 15'(dur) * 15'd205;
    q    = prod[14:11];
    q10  = 7'(q) * 7'd10;
    return 4'(dur - q10);
  endfunction

  // whole minutes shown as MMSS
  function automatic logic [DISP_W-1:0] dur_display(input logic [DUR_W-1:0] dur);
    if (dur > 7'd99) begin
      return DISP_SAT;
    end
    return 14'(dur) * 14'd100;
  endfunction

endpackage

`default_nettype wire

[rtl/core/countdown_session_timer.sv]
// ---------------------------------------------------------------------------
// countdown_session_timer
// Two-button countdown timer with an MMSS display and a dot pattern.
// ---------------------------------------------------------------------------
// Usage: each input transfer (in_req_type, in_now_ms) is a time tick or a
// press of button A or B, and yields exactly one result transfer carrying
// the MMSS display value, the dot pattern and the mode after that item.
// Throughput is one item per cycle while out_stall stays low: the mode,
// duration and time registers are updated from the input register.
// Results pass through the pipeline: input register, state update, time
// left, ms to seconds, seconds to minutes and the output register.
// When the receiver raises out_stall the result holds; upstream stages keep
// taking items until every stage is full, and only then in_stall rises.
// Reset (rst_n low, synchronous) empties the pipeline and returns the timer
// to idle with a 25 minute duration and both time stamps cleared. Ringing
// mode is left only through reset.
// ---------------------------------------------------------------------------
`default_nettype none

module countdown_session_timer #(
  parameter int TIME_BITS = cst_pkg::CST_TIME_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [cst_pkg::REQ_W-1:0]   in_req_type,
  input  wire logic [cst_pkg::NOW_W-1:0]   in_now_ms,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [cst_pkg::DISP_W-1:0]       out_display_value,
  output logic [cst_pkg::DOT_W-1:0]        out_dot_pattern,
  output logic [cst_pkg::MODE_W-1:0]       out_mode
);
  import cst_pkg::*;

  logic      snap_valid;
  logic      snap_ready;
  disp_req_t snap;

  cst_state #(
    .TIME_BITS (TIME_BITS)
  ) u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_now_ms   (in_now_ms),
    .snap_valid  (snap_valid),
    .snap_ready  (snap_ready),
    .snap        (snap)
  );

  cst_disp u_disp (
    .clk               (clk),
    .rst_n             (rst_n),
    .snap_valid        (snap_valid),
    .snap_ready        (snap_ready),
    .snap              (snap),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_display_value (out_display_value),
    .out_dot_pattern   (out_dot_pattern),
    .out_mode          (out_mode)
  );

  // ringing shows a blank display with all dots lit
  a_ring_display: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_mode == MODE_W'(MODE_RING)) |->
      (out_display_value == '0 && out_dot_pattern == DOTS_RING))
    else $error("ring result with wrong display or dots");

  // display never goes past 99:59
  a_disp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_display_value <= DISP_SAT))
    else $error("display value out of range");

  // once a ring result is transferred, every later result rings too
  a_ring_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_mode == MODE_W'(MODE_RING)) |=>
      (!out_valid || out_mode == MODE_W'(MODE_RING)))
    else $error("timer left ringing without reset");

  // idle shows the idle dots
  a_idle_dots: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_mode == MODE_W'(MODE_IDLE)) |-> (out_dot_pattern == DOTS_IDLE))
    else $error("idle result with wrong dots");

endmodule

`default_nettype wire

[rtl/core/cst_state.sv]
// ---------------------------------------------------------------------------
// cst_state
// Input register, mode/duration/time state update and time-left stage.
// ---------------------------------------------------------------------------
`default_nettype none

module cst_state #(
  parameter int TIME_BITS = cst_pkg::CST_TIME_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [cst_pkg::REQ_W-1:0]  in_req_type,
  input  wire logic [cst_pkg::NOW_W-1:0]  in_now_ms,
  output logic                            snap_valid,
  input  wire logic                       snap_ready,
  output cst_pkg::disp_req_t              snap
);
  import cst_pkg::*;

  // stage a: input register
  logic                 a_vld_r;
  logic [REQ_W-1:0]     a_req_r;
  logic [TIME_BITS-1:0] a_now_r;
  logic                 a_rdy, a_go;

  // timer state
  mode_t                mode_r, mode_nxt;
  logic [DUR_W-1:0]     dur_r, dur_nxt;
  logic [TIME_BITS-1:0] end_r, end_nxt;
  logic [TIME_BITS-1:0] last_r, last_nxt;

  // stage b: state snapshot after the update
  logic                 b_vld_r;
  mode_t                b_mode_r;
  logic [DUR_W-1:0]     b_dur_r;
  logic [TIME_BITS-1:0] b_end_r;
  logic [TIME_BITS-1:0] b_last_r;
  logic                 b_rdy;

  // stage c: display request
  logic                 c_vld_r;
  disp_req_t            c_req_r, c_req_nxt;
  logic                 c_rdy;

  logic [TIME_BITS-1:0] tick_diff;
  logic [REM_W-1:0]     dur_ms;
  logic [3:0]           units;
  logic [TIME_BITS-1:0] left_diff;
  logic                 left_pos;
  logic                 left_sat;

  assign c_rdy    = !c_vld_r || snap_ready;
  assign b_rdy    = !b_vld_r || c_rdy;
  assign a_rdy    = !a_vld_r || b_rdy;
  assign a_go     = a_vld_r && b_rdy;
  assign in_stall = !a_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (a_rdy) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_rdy) begin
      a_req_r <= in_req_type;
      a_now_r <= TIME_BITS'(in_now_ms);
    end
  end

  assign tick_diff = a_now_r - last_r;
  assign dur_ms    = REM_W'(dur_r) * REM_W'(MS_PER_MIN);
  assign units     = ones_digit(dur_r);

  // next mode
  always_comb begin
    mode_nxt = mode_r;
    unique case (a_req_r)
      REQ_TICK: begin
        if (mode_r == MODE_RUN && a_now_r >= end_r) begin
          mode_nxt = MODE_RING;
        end
      end
      REQ_BTN_A: begin
        unique case (mode_r)
          MODE_IDLE:  mode_nxt = MODE_RUN;
          MODE_RUN:   mode_nxt = MODE_PAUSE;
          MODE_PAUSE: mode_nxt = MODE_RUN;
          default:    mode_nxt = mode_r;
        endcase
      end
      REQ_BTN_B: begin
        unique case (mode_r)
          MODE_IDLE:  mode_nxt = MODE_TENS;
          MODE_TENS:  mode_nxt = MODE_UNITS;
          MODE_UNITS: mode_nxt = MODE_IDLE;
          MODE_PAUSE: mode_nxt = MODE_IDLE;
          default:    mode_nxt = mode_r;
        endcase
      end
      default: mode_nxt = mode_r;
    endcase
  end

  // duration and time registers
  always_comb begin
    dur_nxt  = dur_r;
    end_nxt  = end_r;
    last_nxt = last_r;
    unique case (a_req_r)
      REQ_TICK: begin
        last_nxt = a_now_r;
        // paused: the end time slides by the elapsed time
        if (mode_r == MODE_PAUSE) begin
          end_nxt = end_r + tick_diff;
        end
      end
      REQ_BTN_A: begin
        unique case (mode_r)
          MODE_IDLE: end_nxt = last_r + TIME_BITS'(dur_ms);
          MODE_TENS: begin
            if (dur_r >= 7'd90) begin
              dur_nxt = 7'd1;
            end else if (dur_r == 7'd1) begin
              dur_nxt = 7'd10;
            end else begin
              dur_nxt = dur_r + 7'd10;
            end
          end
          MODE_UNITS: begin
            if (units == 4'd9) begin
              dur_nxt = (dur_r >= 7'd10) ? dur_r - 7'd9 : dur_r - 7'd8;
            end else begin
              dur_nxt = dur_r + 7'd1;
            end
          end
          default: dur_nxt = dur_r;
        endcase
      end
      REQ_BTN_B: begin
        unique case (mode_r)
          MODE_IDLE:  dur_nxt = 7'd1;
          MODE_PAUSE: end_nxt = '0;
          default:    dur_nxt = dur_r;
        endcase
      end
      default: dur_nxt = dur_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      dur_r  <= DUR_RESET;
      end_r  <= '0;
      last_r <= '0;
    end else if (a_go) begin
      mode_r <= mode_nxt;
      dur_r  <= dur_nxt;
      end_r  <= end_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_rdy) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      b_mode_r <= mode_nxt;
      b_dur_r  <= dur_nxt;
      b_end_r  <= end_nxt;
      b_last_r <= last_nxt;
    end
  end

  // time left, zero when either time is unset or the end has passed
  assign left_diff = b_end_r - b_last_r;
  assign left_pos  = (b_end_r != '0) && (b_last_r != '0) && (b_end_r > b_last_r);
  assign left_sat  = left_pos && (left_diff >= TIME_BITS'(SAT_MS));

  always_comb begin
    c_req_nxt.mode   = b_mode_r;
    c_req_nxt.direct = 1'b1;
    c_req_nxt.dval   = '0;
    c_req_nxt.rem    = '0;
    unique case (b_mode_r) inside
      MODE_IDLE, MODE_TENS, MODE_UNITS: begin
        c_req_nxt.dval = dur_display(b_dur_r);
      end
      MODE_RUN, MODE_PAUSE: begin
        c_req_nxt.direct = left_sat;
        c_req_nxt.dval   = DISP_SAT;
        c_req_nxt.rem    = left_pos ? left_diff[REM_W-1:0] : '0;
      end
      default: c_req_nxt.dval = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (c_rdy) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_vld_r && c_rdy) begin
      c_req_r <= c_req_nxt;
    end
  end

  assign snap_valid = c_vld_r;
  assign snap       = c_req_r;

endmodule

`default_nettype wire

[rtl/core/cst_disp.sv]
// ---------------------------------------------------------------------------
// cst_disp
// Display pipeline: ms to seconds, seconds to minutes, MMSS and dots.
// ---------------------------------------------------------------------------
`default_nettype none

module cst_disp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        snap_valid,
  output logic                             snap_ready,
  input  wire cst_pkg::disp_req_t          snap,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [cst_pkg::DISP_W-1:0]       out_display_value,
  output logic [cst_pkg::DOT_W-1:0]        out_dot_pattern,
  output logic [cst_pkg::MODE_W-1:0]       out_mode
);
  import cst_pkg::*;

  // x / 1000 as ((x >> 3) * RCP_125) >> 27, exact for x below 2^23
  localparam logic [20:0] RCP_125 = 21'd1073742;
  // y / 15 as (y * RCP_15) >> 15, exact for y below 4681
  localparam logic [11:0] RCP_15  = 12'd2185;

  logic              d_vld_r, d_rdy;
  mode_t             d_mode_r;
  logic              d_direct_r;
  logic [DISP_W-1:0] d_dval_r;
  logic [13:0]       d_secs_r;

  logic              e_vld_r, e_rdy;
  mode_t             e_mode_r;
  logic              e_direct_r;
  logic [DISP_W-1:0] e_dval_r;
  logic [13:0]       e_secs_r;
  logic [7:0]        e_mins_r;

  logic              o_vld_r, o_rdy;
  logic [DISP_W-1:0] o_disp_r, o_disp_nxt;
  logic [DOT_W-1:0]  o_dots_r, o_dots_nxt;
  mode_t             o_mode_r;

  logic [40:0]       secs_prod;
  logic [23:0]       mins_prod;
  logic [13:0]       min_sec;
  logic [5:0]        sec_part;

  assign o_rdy      = !o_vld_r || !out_stall;
  assign e_rdy      = !e_vld_r || o_rdy;
  assign d_rdy      = !d_vld_r || e_rdy;
  assign snap_ready = d_rdy;

  assign secs_prod = 41'(snap.rem[REM_W-1:3]) * 41'(RCP_125);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (d_rdy) begin
      d_vld_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && d_rdy) begin
      d_mode_r   <= snap.mode;
      d_direct_r <= snap.direct;
      d_dval_r   <= snap.dval;
      d_secs_r   <= secs_prod[40:27];
    end
  end

  assign mins_prod = 24'(d_secs_r[13:2]) * 24'(RCP_15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (e_rdy) begin
      e_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (d_vld_r && e_rdy) begin
      e_mode_r   <= d_mode_r;
      e_direct_r <= d_direct_r;
      e_dval_r   <= d_dval_r;
      e_secs_r   <= d_secs_r;
      e_mins_r   <= mins_prod[22:15];
    end
  end

  // seconds within the minute
  assign min_sec  = e_secs_r - 14'(e_mins_r) * 14'd60;
  assign sec_part = min_sec[5:0];

  always_comb begin
    if (e_direct_r) begin
      o_disp_nxt = e_dval_r;
    end else begin
      o_disp_nxt = 14'(e_mins_r) * 14'd100 + 14'(sec_part);
    end
  end

  always_comb begin
    unique case (e_mode_r)
      MODE_IDLE:  o_dots_nxt = DOTS_IDLE;
      MODE_RUN:   o_dots_nxt = DOTS_RUN;
      MODE_PAUSE: o_dots_nxt = DOTS_PAUSE;
      MODE_TENS:  o_dots_nxt = DOTS_TENS;
      MODE_UNITS: o_dots_nxt = DOTS_UNITS;
      default:    o_dots_nxt = DOTS_RING;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (o_rdy) begin
      o_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (e_vld_r && o_rdy) begin
      o_disp_r <= o_disp_nxt;
      o_dots_r <= o_dots_nxt;
      o_mode_r <= e_mode_r;
    end
  end

  assign out_valid         = o_vld_r;
  assign out_display_value = o_disp_r;
  assign out_dot_pattern   = o_dots_r;
  assign out_mode          = MODE_W'(o_mode_r);

endmodule

`default_nettype wire
